// ----- rtl/core/assert_macros.svh -----
// Assertion helpers; the enclosing module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FDRF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define FDRF_ASSERT_STABLE(label, cond, sig, msg) \
	`FDRF_ASSERT(label, (cond) |=> $stable(sig), msg)

`endif

// ----- rtl/core/fdrf_pkg.sv -----
package fdrf_pkg;

	localparam int unsigned SHADOW_DEPTH = 8192;
	localparam int unsigned ADDR_W = $clog2(SHADOW_DEPTH);
	localparam int unsigned POS_W = ADDR_W + 1;
	localparam int unsigned LEN_W = 14;
	localparam int unsigned GAP_W = 5;
	localparam int unsigned PADDR_W = 4;

	typedef enum logic [1:0] {
		REG_PIXELS_PER_BYTE = 2'd0,
		REG_MAX_GAP = 2'd1,
		REG_BASE_ADDRESS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [3:0] pixels_per_byte;
		logic [3:0] max_gap;
		logic [15:0] base_address;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic changed;
		logic store;
		logic last;
		logic [POS_W-1:0] pos;
	} byte_info_t;

	// MSB-first packing: pixel 0 lands in the highest used bit.
	function automatic logic [7:0] pack_byte(input logic [7:0] pix, input logic [3:0] ppb);
		logic [3:0] n;
		logic [3:0] idx;
		logic [7:0] b;
		n = (ppb > 4'd8) ? 4'd8 : ppb;
		b = '0;
		for (int j = 0; j < 8; j++) begin
			idx = n - 4'd1 - 4'(j);
			if (4'(j) < n) begin
				b[j] = pix[idx[2:0]];
			end
		end
		return b;
	endfunction

endpackage

// ----- rtl/core/fdrf_pixel_if.sv -----
interface fdrf_pixel_if;
	logic valid;
	logic ready;
	logic [7:0] pixels;
	logic last_of_frame;

	modport source(output valid, output pixels, output last_of_frame, input ready);
	modport sink(input valid, input pixels, input last_of_frame, output ready);
endinterface

// ----- rtl/core/fdrf_run_if.sv -----
interface fdrf_run_if;
	logic valid;
	logic ready;
	logic [15:0] run_address;
	logic [13:0] run_length;
	logic frame_done;
	logic overflow;

	modport source(output valid, output run_address, output run_length, output frame_done,
		output overflow, input ready);
	modport sink(input valid, input run_address, input run_length, input frame_done,
		input overflow, output ready);
endinterface

// ----- rtl/core/fdrf_ram.sv -----
module fdrf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 8192
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/fdrf_cfg_regs.sv -----
module fdrf_cfg_regs import fdrf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	reg_idx_t idx;
	logic wr;
	cfg_t cfg_q;

	assign idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixels_per_byte <= 4'd6;
			cfg_q.max_gap <= 4'd4;
			cfg_q.base_address <= 16'h0200;
		end else if (wr) begin
			case (idx)
				REG_PIXELS_PER_BYTE: cfg_q.pixels_per_byte <= pwdata[3:0];
				REG_MAX_GAP: cfg_q.max_gap <= pwdata[3:0];
				REG_BASE_ADDRESS: cfg_q.base_address <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PIXELS_PER_BYTE: prdata = {28'd0, cfg_q.pixels_per_byte};
			REG_MAX_GAP: prdata = {28'd0, cfg_q.max_gap};
			REG_BASE_ADDRESS: prdata = {16'd0, cfg_q.base_address};
			default: prdata = 32'd0;
		endcase
	end

endmodule

// ----- rtl/core/fdrf_shadow.sv -----
module fdrf_shadow import fdrf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	fdrf_pixel_if.sink pix,
	input logic take,
	output byte_info_t info
);

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] fill_q;
	logic valid_s1;
	logic [7:0] pixels_s1;
	logic last_s1;
	logic [POS_W-1:0] pos_s1;
	logic store_s1;
	logic hit_s1;
	logic fwd_s1;
	logic [7:0] fwd_data_s1;

	logic accept;
	logic go;
	logic store_in;
	logic [7:0] byte_s1;
	logic [7:0] rdata;
	logic [7:0] old_byte;

	assign go = valid_s1 && take;
	assign pix.ready = !valid_s1 || take;
	assign accept = pix.valid && pix.ready;
	assign store_in = pos_q < POS_W'(SHADOW_DEPTH);
	assign byte_s1 = pack_byte(pixels_s1, cfg.pixels_per_byte);

	fdrf_ram #(
		.WIDTH(8),
		.DEPTH(SHADOW_DEPTH)
	) u_shadow_ram (
		.clk(clk),
		.we(go && store_s1),
		.waddr(pos_s1[ADDR_W-1:0]),
		.wdata(byte_s1),
		.re(accept && store_in),
		.raddr(pos_q[ADDR_W-1:0]),
		.rdata(rdata)
	);

	// entries at or past the fill mark were never written since reset and read as zero
	always_comb begin
		if (fwd_s1) begin
			old_byte = fwd_data_s1;
		end else if (hit_s1) begin
			old_byte = rdata;
		end else begin
			old_byte = 8'd0;
		end
	end

	assign info.valid = valid_s1;
	assign info.changed = store_s1 && (old_byte != byte_s1);
	assign info.store = store_s1;
	assign info.last = last_s1;
	assign info.pos = pos_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			fill_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (pix.last_of_frame) begin
					pos_q <= '0;
				end else if (store_in) begin
					pos_q <= pos_q + POS_W'(1);
				end
				if (store_in && pos_q >= fill_q) begin
					fill_q <= pos_q + POS_W'(1);
				end
			end else if (go) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixels_s1 <= pix.pixels;
			last_s1 <= pix.last_of_frame;
			pos_s1 <= pos_q;
			store_s1 <= store_in;
			hit_s1 <= pos_q < fill_q;
			fwd_s1 <= go && store_s1 && (pos_s1 == pos_q);
			fwd_data_s1 <= byte_s1;
		end
	end

endmodule

// ----- rtl/core/fdrf_run_tracker.sv -----
module fdrf_run_tracker import fdrf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input byte_info_t info,
	output logic take,
	fdrf_run_if.source run
);

	logic run_open_q;
	logic [ADDR_W-1:0] run_first_q;
	logic [GAP_W-1:0] unch_q;
	logic overflow_q;
	logic out_valid_q;
	logic [15:0] run_address_q;
	logic [LEN_W-1:0] run_length_q;
	logic frame_done_q;
	logic overflow_out_q;

	logic go;
	logic eff_open;
	logic [ADDR_W-1:0] eff_first;
	logic [GAP_W-1:0] eff_unch;
	logic close;
	logic res_valid;
	logic ovf_eff;
	logic [POS_W-1:0] last_pos;
	logic [POS_W-1:0] len_full;
	logic [15:0] res_address;
	logic [LEN_W-1:0] res_length;

	assign take = !out_valid_q || run.ready;
	assign go = info.valid && take;

	always_comb begin
		if (info.changed) begin
			eff_unch = '0;
		end else if (run_open_q) begin
			eff_unch = unch_q + GAP_W'(1);
		end else begin
			eff_unch = unch_q;
		end
	end

	assign eff_open = info.changed || run_open_q;
	assign eff_first = (info.changed && !run_open_q) ? info.pos[ADDR_W-1:0] : run_first_q;
	assign close = !info.changed && run_open_q && (eff_unch > GAP_W'(cfg.max_gap));
	assign res_valid = close || info.last;
	assign ovf_eff = overflow_q || !info.store;

	// run ends at the last changed byte
	assign last_pos = info.pos - POS_W'(eff_unch);
	assign len_full = last_pos - POS_W'(eff_first) + POS_W'(1);
	assign res_address = eff_open ? cfg.base_address + 16'(eff_first) : 16'd0;
	assign res_length = eff_open ? LEN_W'(len_full) : '0;

	assign run.valid = out_valid_q;
	assign run.run_address = run_address_q;
	assign run.run_length = run_length_q;
	assign run.frame_done = frame_done_q;
	assign run.overflow = overflow_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			run_first_q <= '0;
			unch_q <= '0;
			overflow_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				out_valid_q <= res_valid;
				if (info.last) begin
					run_open_q <= 1'b0;
					run_first_q <= '0;
					unch_q <= '0;
					overflow_q <= 1'b0;
				end else begin
					overflow_q <= ovf_eff;
					if (close) begin
						run_open_q <= 1'b0;
						unch_q <= '0;
					end else begin
						run_open_q <= eff_open;
						run_first_q <= eff_first;
						unch_q <= eff_unch;
					end
				end
			end else if (run.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			run_address_q <= res_address;
			run_length_q <= res_length;
			frame_done_q <= info.last;
			overflow_out_q <= info.last && ovf_eff;
		end
	end

endmodule

// ----- rtl/core/framebuffer_dirty_run_finder.sv -----
// Dirty-run finder: takes one display byte per cycle and compares it against an 8192-byte
// shadow of the previous frame held in one RAM with a registered read (read when the byte is
// accepted, written back when it leaves the input stage, with a bypass when the next byte
// reads the same address in that cycle). A result is registered as its byte leaves the input
// stage, and only when a run closes on a gap or at the frame end. While a result waits in the
// output register, one more byte can enter the input stage, then the input stalls until the
// result is taken. The shadow reads as all zero after reset through a fill mark, so no
// clearing pass is needed and the block accepts bytes straight after reset.
module framebuffer_dirty_run_finder import fdrf_pkg::*; (
	input logic clk,
	input logic arst_n,
	fdrf_pixel_if.sink pixel_in,
	fdrf_run_if.source run_out,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	cfg_t cfg;
	byte_info_t info;
	logic take;

	fdrf_cfg_regs u_cfg_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	fdrf_shadow u_shadow (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pix(pixel_in),
		.take(take),
		.info(info)
	);

	fdrf_run_tracker u_run_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.info(info),
		.take(take),
		.run(run_out)
	);

endmodule

// ----- rtl/core/fdrf_checker.sv -----
`include "assert_macros.svh"

module fdrf_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [15:0] run_address,
	input logic [13:0] run_length,
	input logic frame_done,
	input logic overflow
);

	`FDRF_ASSERT(a_valid_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`FDRF_ASSERT_STABLE(a_addr_hold, out_valid && !out_ready, run_address, "address moved while stalled")
	`FDRF_ASSERT(a_gap_len, out_valid && !frame_done |-> run_length != 14'd0, "empty run on gap close")
	`FDRF_ASSERT(a_ovf_final, out_valid && overflow |-> frame_done, "overflow outside frame end")

endmodule

bind framebuffer_dirty_run_finder fdrf_checker u_fdrf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(run_out.valid),
	.out_ready(run_out.ready),
	.run_address(run_out.run_address),
	.run_length(run_out.run_length),
	.frame_done(run_out.frame_done),
	.overflow(run_out.overflow)
);
